// File: hw/rtl/bsmf_pkg.sv
// Package for the byte-set mode finder: shared types and constants.
package bsmf_pkg;

  // Default capacity of the value store
  localparam int MaxElemsDefault = 16;
  // Most results emitted for one set
  localparam int MaxResults = 16;
  // Width and saturation limit of the reported frequency
  localparam int FreqW = 5;
  localparam int FreqMax = 31;

  // One input transaction
  typedef struct packed {
    logic [7:0] element_value;
    logic       last_element;
  } bsmf_in_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]       mode_value;
    logic [FreqW-1:0] mode_frequency;
    logic             tie_present;
    logic             overflow_seen;
    logic             last_mode;
  } bsmf_out_t;

endpackage

// File: hw/rtl/bsmf_store.sv
// Value store and per-entry count store, one write and one registered read each.
module bsmf_store import bsmf_pkg::*; #(
  parameter int MaxElems = MaxElemsDefault,
  localparam int AW = (MaxElems > 1) ? $clog2(MaxElems) : 1,
  localparam int CW = $clog2(MaxElems + 1)
) (
  input  logic          clk_i,
  input  logic          val_we_i,
  input  logic [AW-1:0] val_waddr_i,
  input  logic [7:0]    val_wdata_i,
  input  logic          cnt_we_i,
  input  logic [AW-1:0] cnt_waddr_i,
  input  logic [CW-1:0] cnt_wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rval_o,
  output logic [CW-1:0] rcnt_o
);

  logic [7:0]    val_mem [MaxElems];
  logic [CW-1:0] cnt_mem [MaxElems];

  // value memory: write port and registered read
  always_ff @(posedge clk_i) begin
    if (val_we_i) begin
      val_mem[val_waddr_i] <= val_wdata_i;
    end
    rval_o <= val_mem[raddr_i];
  end

  // count memory: write port and registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we_i) begin
      cnt_mem[cnt_waddr_i] <= cnt_wdata_i;
    end
    rcnt_o <= cnt_mem[raddr_i];
  end

endmodule

// File: hw/rtl/byte_set_mode_finder_top.sv
// Top level of the byte-set mode finder: loading, counting and result sequencer.
// Loading: one value per cycle, busy stays low until the marked last value is taken.
// Evaluation with n stored values: counting compares each entry against every stored
// entry over the single read port, one compare a cycle; each result search is a scan
// of all n stored values, one scan per result plus one in all-modes mode.
// Results come one strobe each, never stalled; busy is low in the cycle of the last strobe.
// Reset clears control state and sets the all-modes setting cfg_all_q to 1; store contents are undefined.
module byte_set_mode_finder_top import bsmf_pkg::*; #(
  parameter int MaxElems = MaxElemsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  bsmf_in_t  in_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output logic      res_valid_o,
  output bsmf_out_t res_o
);

  localparam int AW = (MaxElems > 1) ? $clog2(MaxElems) : 1;
  localparam int CW = $clog2(MaxElems + 1);
  localparam int FW = (CW > FreqW) ? CW : FreqW;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDI   = 3'd1;
  localparam logic [2:0] S_LDI   = 3'd2;
  localparam logic [2:0] S_CSCAN = 3'd3;
  localparam logic [2:0] S_EINIT = 3'd4;
  localparam logic [2:0] S_ESCAN = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic             cfg_all_q;
  logic [CW-1:0]    i_q, i_d;
  logic [CW-1:0]    sc_q, sc_d;
  logic             issue_q, issue_d;
  logic [7:0]       cand_q, cand_d;
  logic [CW-1:0]    acc_q, acc_d;
  logic [CW-1:0]    top_q, top_d;
  logic [CW-1:0]    m_q, m_d;
  logic [7:0]       best_q, best_d;
  logic             best_vld_q, best_vld_d;
  logic [7:0]       pend_q, pend_d;
  logic             have_pend_q, have_pend_d;
  logic [7:0]       prev_q, prev_d;
  logic [FreqW-1:0] ecnt_q, ecnt_d;
  bsmf_out_t        res_q, res_d;
  logic             res_valid_q, res_valid_d;

  logic             val_we, cnt_we;
  logic [AW-1:0]    raddr;
  logic [7:0]       rval;
  logic [CW-1:0]    rcnt;
  logic             accept, scan_end, qualifies, finish_set;
  logic [FW-1:0]    top_ext;
  logic [FreqW-1:0] freq;

  bsmf_store #(
    .MaxElems(MaxElems)
  ) u_store (
    .clk_i      (clk_i),
    .val_we_i   (val_we),
    .val_waddr_i(fill_q[AW-1:0]),
    .val_wdata_i(in_i.element_value),
    .cnt_we_i   (cnt_we),
    .cnt_waddr_i(i_q[AW-1:0]),
    .cnt_wdata_i(acc_q),
    .raddr_i    (raddr),
    .rval_o     (rval),
    .rcnt_o     (rcnt)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign val_we = accept && (fill_q < CW'(MaxElems));
  assign raddr  = (state_q == S_RDI) ? i_q[AW-1:0] : sc_q[AW-1:0];

  // scan done once all addresses issued and the last read data consumed
  assign scan_end = (sc_q == fill_q) && !issue_q;
  assign cnt_we   = (state_q == S_CSCAN) && scan_end;

  // saturated frequency
  assign top_ext = FW'(top_q);
  assign freq    = (top_ext > FW'(FreqMax)) ? FreqW'(FreqMax) : top_ext[FreqW-1:0];

  // candidate test for the result search
  always_comb begin
    qualifies = 1'b0;
    if (issue_q && (rcnt == top_q)) begin
      if (cfg_all_q) begin
        qualifies = (!have_pend_q || (rval > prev_q)) && (!best_vld_q || (rval < best_q));
      end else begin
        qualifies = !best_vld_q || (rval > best_q);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    sc_d        = sc_q;
    issue_d     = issue_q;
    cand_d      = cand_q;
    acc_d       = acc_q;
    top_d       = top_q;
    m_d         = m_q;
    best_d      = best_q;
    best_vld_d  = best_vld_q;
    pend_d      = pend_q;
    have_pend_d = have_pend_q;
    prev_d      = prev_q;
    ecnt_d      = ecnt_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    finish_set  = 1'b0;

    // common result fields
    res_d.mode_frequency = freq;
    res_d.tie_present    = (m_q > top_q);
    res_d.overflow_seen  = ovf_q;

    // address issue for both scan kinds
    if ((state_q == S_CSCAN) || (state_q == S_ESCAN)) begin
      if (sc_q != fill_q) begin
        sc_d    = sc_q + CW'(1);
        issue_d = 1'b1;
      end else begin
        issue_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (val_we) begin
            fill_d = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_element) begin
            i_d     = '0;
            top_d   = '0;
            m_d     = '0;
            state_d = S_RDI;
          end
        end
      end
      S_RDI: begin
        state_d = S_LDI;
      end
      S_LDI: begin
        cand_d  = rval;
        sc_d    = '0;
        issue_d = 1'b0;
        acc_d   = '0;
        state_d = S_CSCAN;
      end
      S_CSCAN: begin
        if (issue_q && (rval == cand_q)) begin
          acc_d = acc_q + CW'(1);
        end
        if (scan_end) begin
          // running top count and number of entries that reach it
          if (acc_q > top_q) begin
            top_d = acc_q;
            m_d   = CW'(1);
          end else if (acc_q == top_q) begin
            m_d = m_q + CW'(1);
          end
          if (i_q + CW'(1) == fill_q) begin
            state_d = S_EINIT;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_RDI;
          end
        end
      end
      S_EINIT: begin
        sc_d       = '0;
        issue_d    = 1'b0;
        best_vld_d = 1'b0;
        state_d    = S_ESCAN;
      end
      S_ESCAN: begin
        if (qualifies) begin
          best_d     = rval;
          best_vld_d = 1'b1;
        end
        if (scan_end) begin
          if (!cfg_all_q) begin
            // largest tied mode only
            res_d.mode_value = best_q;
            res_d.last_mode  = 1'b1;
            res_valid_d      = 1'b1;
            finish_set       = 1'b1;
          end else if (!best_vld_q) begin
            // no further mode: pending one is the last
            res_d.mode_value = pend_q;
            res_d.last_mode  = 1'b1;
            res_valid_d      = 1'b1;
            finish_set       = 1'b1;
          end else begin
            pend_d      = best_q;
            prev_d      = best_q;
            have_pend_d = 1'b1;
            state_d     = S_EINIT;
            if (have_pend_q) begin
              res_d.mode_value = pend_q;
              res_d.last_mode  = (ecnt_q == FreqW'(MaxResults - 1));
              res_valid_d      = 1'b1;
              ecnt_d           = ecnt_q + FreqW'(1);
              if (ecnt_q == FreqW'(MaxResults - 1)) begin
                finish_set = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // set closed: clear for the next one
    if (finish_set) begin
      fill_d      = '0;
      ovf_d       = 1'b0;
      have_pend_d = 1'b0;
      ecnt_d      = '0;
      state_d     = S_IDLE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      cfg_all_q   <= 1'b1;
      issue_q     <= 1'b0;
      have_pend_q <= 1'b0;
      ecnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      issue_q     <= issue_d;
      have_pend_q <= have_pend_d;
      ecnt_q      <= ecnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cfg_all_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    sc_q       <= sc_d;
    cand_q     <= cand_d;
    acc_q      <= acc_d;
    top_q      <= top_d;
    m_q        <= m_d;
    best_q     <= best_d;
    best_vld_q <= best_vld_d;
    pend_q     <= pend_d;
    prev_q     <= prev_d;
    res_q      <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
